### rtl/u8u16_pkg.sv
// Shared types, constants and byte classification helpers for the UTF-8 to UTF-16 decoder.
package u8u16_pkg;

  localparam int unsigned BufDepth = 4;

  localparam logic [15:0] UNIT_REPLACE = 16'hFFFD;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [15:0] SURR_LAST = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h010000;
  localparam logic [20:0] CODE_MAX = 21'h10FFFF;
  localparam logic [15:0] MIN_THREE = 16'h0800;
  localparam logic [10:0] MIN_TWO = 11'h080;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] pos_t;

  typedef enum logic [1:0] {
    SEL_SCAN = 2'd0,
    SEL_LO   = 2'd1,
    SEL_TAIL = 2'd2
  } unit_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    unit_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic stop;
    logic tail;
    logic pair;
    logic last_adv;
    logic last_now;
    logic out_free;
    pos_t count;
    pos_t pos;
  } dp_sts_t;

  function automatic pos_t lead_len(input byte_t b);
    pos_t len;
    len = 3'd0;
    if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic stop_at(input byte_t b, input pos_t x, input pos_t n);
    pos_t       len;
    logic [3:0] reach;
    len = lead_len(b);
    reach = {1'b0, x} + {1'b0, len};
    return (x >= n) || ((len != 3'd0) && (reach > {1'b0, n}));
  endfunction

endpackage

### rtl/utf8_to_utf16_lossy_decoder.sv
// Top level of the lossy UTF-8 to UTF-16 decoder: controller, datapath and checks.
// Each byte is taken and appended to a four-byte buffer of held bytes; the decoder then
// walks that buffer with a scan pointer and produces one UTF-16 code unit per cycle into
// the output register while the result side does not stall. A byte may yield further
// units (a surrogate pair, a replacement for an invalid sequence followed by rescanned
// bytes, or the replacement at the end of a truncated text), and a byte that only extends
// a held sequence yields no unit. Stalls on the result side hold the scan. No new byte is
// taken while the scan runs; the next byte is taken while the last unit still waits in
// the output register.
module utf8_to_utf16_lossy_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_text_byte,
  input  logic        in_final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_code_unit,
  output logic        out_run_end,
  output logic        out_text_end
);

  u8u16_pkg::dp_cmd_t cmd;
  u8u16_pkg::dp_sts_t sts;

  u8u16_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  u8u16_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_unit (out_code_unit),
    .out_run_end   (out_run_end),
    .out_text_end  (out_text_end),
    .cmd           (cmd),
    .sts           (sts)
  );

  // The end of a text always closes the run of the byte that caused it.
  a_text_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_end |-> out_run_end)
    else $error("text end without run end");

  // A high surrogate is always followed by its low half within the same run.
  a_high_surrogate_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_code_unit[15:10] == 6'b110110) |-> !out_run_end)
    else $error("high surrogate closes a run");

  // The scan pointer never passes the number of buffered bytes.
  a_pointer_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sts.count <= 3'd4) && (sts.pos <= sts.count))
    else $error("scan pointer out of range");

  // Loading a byte and emitting a unit never happen in the same cycle.
  a_load_emit_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !cmd.emit)
    else $error("load and emit together");

endmodule

### rtl/u8u16_ctrl.sv
// Controller state machine: takes bytes, steps the scan and issues unit transfers.
module u8u16_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  u8u16_pkg::dp_sts_t  sts,
  output u8u16_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_LO   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    cmd.sel   = u8u16_pkg::SEL_SCAN;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.stop) begin
          if (sts.tail) begin
            if (sts.out_free) begin
              cmd.emit  = 1'b1;
              cmd.sel   = u8u16_pkg::SEL_TAIL;
              state_nxt = ST_IDLE;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end else if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = u8u16_pkg::SEL_SCAN;
          if (sts.pair) begin
            state_nxt = ST_LO;
          end else if (sts.last_adv) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LO: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = u8u16_pkg::SEL_LO;
          state_nxt = sts.last_now ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/u8u16_dp.sv
// Datapath: byte buffer, scan pointer, sequence decoder and output register.
module u8u16_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          in_text_byte,
  input  logic                in_final_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [15:0]         out_code_unit,
  output logic                out_run_end,
  output logic                out_text_end,
  input  u8u16_pkg::dp_cmd_t  cmd,
  output u8u16_pkg::dp_sts_t  sts
);

  u8u16_pkg::byte_t buf_r [u8u16_pkg::BufDepth];
  u8u16_pkg::byte_t buf_nxt [u8u16_pkg::BufDepth];
  u8u16_pkg::pos_t  cnt_r, cnt_nxt;
  u8u16_pkg::pos_t  pos_r, pos_nxt;
  logic             fin_r, fin_nxt;
  logic [15:0]      lo_r, lo_nxt;
  logic             out_valid_r;
  logic [15:0]      code_r;
  logic             run_end_r;
  logic             text_end_r;

  u8u16_pkg::byte_t w0, w1, w2, w3;
  u8u16_pkg::pos_t  len, adv, pos_adv, rest, idx;
  logic [10:0]      cp2;
  logic [15:0]      cp3;
  logic [20:0]      cp4;
  logic [20:0]      off;
  logic             cont_ok, seq_ok;
  logic [15:0]      unit, hi_unit, lo_unit;
  logic             pair;
  logic             stop_now, stop_adv, tail_now, tail_adv;
  logic             out_free;

  assign w0 = buf_r[pos_r[1:0]];
  assign w1 = buf_r[2'(pos_r[1:0] + 2'd1)];
  assign w2 = buf_r[2'(pos_r[1:0] + 2'd2)];
  assign w3 = buf_r[2'(pos_r[1:0] + 2'd3)];

  assign len = u8u16_pkg::lead_len(w0);
  assign cp2 = {w0[4:0], w1[5:0]};
  assign cp3 = {w0[3:0], w1[5:0], w2[5:0]};
  assign cp4 = {w0[2:0], w1[5:0], w2[5:0], w3[5:0]};
  assign off = cp4 - u8u16_pkg::SUPP_BASE;
  assign hi_unit = u8u16_pkg::HI_SURR_BASE + {6'd0, off[19:10]};
  assign lo_unit = u8u16_pkg::LO_SURR_BASE + {6'd0, off[9:0]};

  assign cont_ok = (w1[7:6] == 2'b10) &&
                   ((len < 3'd3) || (w2[7:6] == 2'b10)) &&
                   ((len < 3'd4) || (w3[7:6] == 2'b10));

  always_comb begin
    seq_ok = 1'b0;
    case (len)
      3'd2: seq_ok = cp2 >= u8u16_pkg::MIN_TWO;
      3'd3: seq_ok = (cp3 >= u8u16_pkg::MIN_THREE) &&
                     !((cp3 >= u8u16_pkg::HI_SURR_BASE) && (cp3 <= u8u16_pkg::SURR_LAST));
      3'd4: seq_ok = (cp4 >= u8u16_pkg::SUPP_BASE) && (cp4 <= u8u16_pkg::CODE_MAX);
      default: seq_ok = 1'b0;
    endcase
    seq_ok = seq_ok && cont_ok;
  end

  always_comb begin
    unit = u8u16_pkg::UNIT_REPLACE;
    adv  = 3'd1;
    pair = 1'b0;
    if (w0[7] == 1'b0) begin
      unit = {8'h00, w0};
    end else if ((len != 3'd0) && seq_ok) begin
      adv = len;
      case (len)
        3'd2: unit = {5'd0, cp2};
        3'd3: unit = cp3;
        default: begin
          unit = hi_unit;
          pair = 1'b1;
        end
      endcase
    end
  end

  assign pos_adv  = pos_r + adv;
  assign stop_now = u8u16_pkg::stop_at(w0, pos_r, cnt_r);
  assign stop_adv = u8u16_pkg::stop_at(buf_r[pos_adv[1:0]], pos_adv, cnt_r);
  assign tail_now = fin_r && (cnt_r > pos_r);
  assign tail_adv = fin_r && (cnt_r > pos_adv);
  assign out_free = !out_valid_r || !out_stall;

  assign sts.stop     = stop_now;
  assign sts.tail     = tail_now;
  assign sts.pair     = pair;
  assign sts.last_adv = stop_adv && !tail_adv;
  assign sts.last_now = stop_now && !tail_now;
  assign sts.out_free = out_free;
  assign sts.count    = cnt_r;
  assign sts.pos      = pos_r;

  assign rest = fin_r ? 3'd0 : (cnt_r - pos_r);

  always_comb begin
    for (int k = 0; k < u8u16_pkg::BufDepth; k++) begin
      idx = pos_r + 3'(k);
      buf_nxt[k] = buf_r[k];
      if (cmd.load) begin
        buf_nxt[k] = (3'(k) < rest) ? buf_r[idx[1:0]] : in_text_byte;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    fin_nxt = fin_r;
    lo_nxt  = lo_r;
    if (cmd.load) begin
      cnt_nxt = rest + 3'd1;
      pos_nxt = 3'd0;
      fin_nxt = in_final_byte;
    end else if (cmd.emit && (cmd.sel == u8u16_pkg::SEL_SCAN)) begin
      pos_nxt = pos_adv;
      lo_nxt  = lo_unit;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < u8u16_pkg::BufDepth; k++) begin
      buf_r[k] <= buf_nxt[k];
    end
    lo_r <= lo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
      pos_r <= 3'd0;
      fin_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.sel)
        u8u16_pkg::SEL_SCAN: begin
          code_r     <= unit;
          run_end_r  <= !pair && sts.last_adv;
          text_end_r <= !pair && sts.last_adv && fin_r;
        end
        u8u16_pkg::SEL_LO: begin
          code_r     <= lo_r;
          run_end_r  <= sts.last_now;
          text_end_r <= sts.last_now && fin_r;
        end
        u8u16_pkg::SEL_TAIL: begin
          code_r     <= u8u16_pkg::UNIT_REPLACE;
          run_end_r  <= 1'b1;
          text_end_r <= 1'b1;
        end
        default: begin
          code_r     <= u8u16_pkg::UNIT_REPLACE;
          run_end_r  <= 1'b1;
          text_end_r <= fin_r;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_code_unit = code_r;
  assign out_run_end   = run_end_r;
  assign out_text_end  = text_end_r;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the lossy UTF-8 to UTF-16 decoder with a built-in predictor.
module testbench;

  localparam int LIMIT = 200000;
  localparam int PREDICT = -1;
  localparam int RANDOM_BYTES = 250;
  localparam int QUIET_FROM = 200;

  typedef struct packed {
    logic [15:0] cu;
    logic        run_end;
    logic        text_end;
  } unit_exp_t;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        last_of_text;
    int          n;
    logic [15:0] u0;
    logic [15:0] u1;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_text_byte = 8'h00;
  logic        in_final_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_code_unit;
  logic        out_run_end;
  logic        out_text_end;

  utf8_to_utf16_lossy_decoder u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_unit (out_code_unit),
    .out_run_end   (out_run_end),
    .out_text_end  (out_text_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  unit_exp_t   pending_units[$];
  logic [7:0]  held_bytes[3];
  int          held_count = 0;
  logic [15:0] step_units[4];
  int          step_n;
  int          typed_n = PREDICT;
  logic [15:0] typed_u[2];
  logic [7:0]  text_q[$];
  dir_row_t    dir_rows[25];
  bit          quiet = 1'b0;
  int          errors = 0;
  int          cycles = 0;
  int          bytes_in = 0;
  int          texts_in = 0;
  int          units_out = 0;
  int          repl_out = 0;
  int          pairs_out = 0;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int utf8_span(input logic [7:0] b);
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  function automatic void add_unit(input logic [15:0] cu);
    if (step_n < 4) begin
      step_units[step_n] = cu;
      step_n++;
    end
  endfunction

  // Appends one byte to the held bytes, decodes everything that is complete and
  // leaves the resulting code units in step_units.
  function automatic void decode_utf8_byte(input logic [7:0] b, input logic last_of_text);
    logic [7:0]  q[5];
    logic [7:0]  b0;
    logic [7:0]  bx;
    logic [20:0] cp;
    logic [20:0] v;
    int          qn;
    int          p;
    int          len;
    int          rest;
    bit          ok;
    step_n = 0;
    qn = held_count;
    for (int k = 0; k < qn; k++) q[k] = held_bytes[k];
    q[qn] = b;
    qn++;
    p = 0;
    while (p < qn) begin
      b0 = q[p];
      if (b0 <= 8'h7F) begin
        add_unit({8'h00, b0});
        p++;
        continue;
      end
      len = utf8_span(b0);
      if (len == 0) begin
        add_unit(u8u16_pkg::UNIT_REPLACE);
        p++;
        continue;
      end
      if (p + len > qn) break;
      case (len)
        2: cp = {16'h0, b0[4:0]};
        3: cp = {17'h0, b0[3:0]};
        default: cp = {18'h0, b0[2:0]};
      endcase
      ok = 1'b1;
      for (int k = 1; k < len; k++) begin
        bx = q[p + k];
        if (bx[7:6] != 2'b10) begin
          ok = 1'b0;
          break;
        end
        cp = (cp << 6) | {15'h0, bx[5:0]};
      end
      if (ok) begin
        if (len == 2 && cp < u8u16_pkg::MIN_TWO) ok = 1'b0;
        if (len == 3 && cp < u8u16_pkg::MIN_THREE) ok = 1'b0;
        if (len == 4 && cp < u8u16_pkg::SUPP_BASE) ok = 1'b0;
        if (cp >= u8u16_pkg::HI_SURR_BASE && cp <= u8u16_pkg::SURR_LAST) ok = 1'b0;
        if (cp > u8u16_pkg::CODE_MAX) ok = 1'b0;
      end
      if (!ok) begin
        add_unit(u8u16_pkg::UNIT_REPLACE);
        p++;
        continue;
      end
      if (cp < u8u16_pkg::SUPP_BASE) begin
        add_unit(cp[15:0]);
      end else begin
        v = cp - u8u16_pkg::SUPP_BASE;
        add_unit(u8u16_pkg::HI_SURR_BASE + {6'h0, v[19:10]});
        add_unit(u8u16_pkg::LO_SURR_BASE + {6'h0, v[9:0]});
      end
      p += len;
    end
    rest = qn - p;
    if (rest > 3) rest = 3;
    for (int k = 0; k < rest; k++) held_bytes[k] = q[p + k];
    held_count = rest;
    if (last_of_text) begin
      if (rest != 0) add_unit(u8u16_pkg::UNIT_REPLACE);
      held_count = 0;
    end
  endfunction

  always @(posedge clk) begin
    unit_exp_t e;
    unit_exp_t w;
    int        n;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        decode_utf8_byte(in_text_byte, in_final_byte);
        n = (typed_n == PREDICT) ? step_n : typed_n;
        for (int k = 0; k < n; k++) begin
          e.cu = (typed_n == PREDICT) ? step_units[k] : typed_u[k];
          e.run_end = (k == n - 1);
          e.text_end = (k == n - 1) && in_final_byte;
          pending_units = {pending_units, e};
        end
        bytes_in++;
        if (in_final_byte) texts_in++;
      end
      if (out_valid && !out_stall) begin
        units_out++;
        if (out_code_unit == u8u16_pkg::UNIT_REPLACE) repl_out++;
        if (out_code_unit[15:10] == u8u16_pkg::HI_SURR_BASE[15:10]) pairs_out++;
        if (pending_units.size() == 0) begin
          report($sformatf("unexpected code unit %h", out_code_unit));
        end else begin
          w = pending_units.pop_front();
          if (out_code_unit !== w.cu)
            report($sformatf("code_unit %h, expected %h", out_code_unit, w.cu));
          if (out_run_end !== w.run_end)
            report($sformatf("run_end %b, expected %b on unit %h", out_run_end, w.run_end,
                             w.cu));
          if (out_text_end !== w.text_end)
            report($sformatf("text_end %b, expected %b on unit %h", out_text_end,
                             w.text_end, w.cu));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Timeout after %0d cycles with %0d units outstanding.", cycles,
               pending_units.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_stall <= 1'b0;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(40, 120)) @(negedge clk);
      else repeat ($urandom_range(0, 30)) @(negedge clk);
      if (!quiet) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19) - 1) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_byte(input logic [7:0] b, input logic last_of_text, input int n,
                           input logic [15:0] u0, input logic [15:0] u1);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    typed_n = n;
    typed_u[0] = u0;
    typed_u[1] = u1;
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_final_byte <= last_of_text;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_units.size() != 0) @(negedge clk);
  endtask

  function automatic dir_row_t row(input logic [7:0] b, input logic last_of_text,
                                   input int n, input logic [15:0] u0,
                                   input logic [15:0] u1);
    dir_row_t r;
    r.text_byte = b;
    r.last_of_text = last_of_text;
    r.n = n;
    r.u0 = u0;
    r.u1 = u1;
    return r;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    text_q = {text_q, b};
  endfunction

  function automatic logic [20:0] pick_cp(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 21'(lo);
    if (r == 1) return 21'(hi);
    return 21'($urandom_range(hi, lo));
  endfunction

  function automatic logic [20:0] valid_cp(input int len);
    logic [20:0] cp;
    case (len)
      2: cp = pick_cp(32'h80, 32'h7FF);
      3: begin
        cp = pick_cp(32'h800, 32'hFFFF);
        if (cp >= u8u16_pkg::HI_SURR_BASE && cp <= u8u16_pkg::SURR_LAST) cp[12] = 1'b0;
      end
      default: cp = pick_cp(32'h10000, 32'h10FFFF);
    endcase
    return cp;
  endfunction

  task automatic append_seq(input logic [20:0] cp, input int len);
    case (len)
      2: begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end
      3: begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
      default: begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Builds one text: mostly well-formed sequences, with some malformed ones mixed in.
  task automatic build_text();
    int tokens;
    int r;
    int len;
    int cut;
    text_q.delete();
    tokens = $urandom_range(1, 10);
    for (int t = 0; t < tokens; t++) begin
      r = $urandom_range(0, 99);
      len = $urandom_range(2, 4);
      if (r < 25) begin
        put_byte(8'($urandom_range(8'h00, 8'h7F)));
      end else if (r < 68) begin
        append_seq(valid_cp(len), len);
      end else if (r < 72) begin
        if ($urandom_range(0, 1) == 0) put_byte(8'($urandom_range(8'h80, 8'hBF)));
        else put_byte(8'($urandom_range(8'hF8, 8'hFF)));
      end else if (r < 76) begin
        case (len)
          2: append_seq(pick_cp(0, 32'h7F), 2);
          3: append_seq(pick_cp(0, 32'h7FF), 3);
          default: append_seq(pick_cp(0, 32'hFFFF), 4);
        endcase
      end else if (r < 79) begin
        append_seq(pick_cp(32'hD800, 32'hDFFF), 3);
      end else if (r < 82) begin
        append_seq(pick_cp(32'h110000, 32'h1FFFFF), 4);
      end else if (r < 90) begin
        append_seq(valid_cp(len), len);
        cut = $urandom_range(1, len - 1);
        text_q[text_q.size() - len + cut] = 8'($urandom_range(0, 255));
      end else if (r < 95) begin
        append_seq(valid_cp(len), len);
        repeat ($urandom_range(1, len - 1)) void'(text_q.pop_back());
      end else begin
        put_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int random_bytes;
    dir_rows[0]  = row(8'h00, 1'b0, 1, 16'h0000, 16'h0000);
    dir_rows[1]  = row(8'h7F, 1'b1, 1, 16'h007F, 16'h0000);
    dir_rows[2]  = row(8'h80, 1'b0, 1, u8u16_pkg::UNIT_REPLACE, 16'h0000);
    dir_rows[3]  = row(8'hFF, 1'b0, 1, u8u16_pkg::UNIT_REPLACE, 16'h0000);
    dir_rows[4]  = row(8'hC3, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[5]  = row(8'hA9, 1'b0, 1, 16'h00E9, 16'h0000);
    dir_rows[6]  = row(8'hC0, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[7]  = row(8'h80, 1'b0, PREDICT, 16'h0000, 16'h0000);
    dir_rows[8]  = row(8'hED, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[9]  = row(8'hA0, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[10] = row(8'h80, 1'b0, PREDICT, 16'h0000, 16'h0000);
    dir_rows[11] = row(8'hF0, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[12] = row(8'h9F, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[13] = row(8'h98, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[14] = row(8'h80, 1'b0, 2, 16'hD83D, 16'hDE00);
    dir_rows[15] = row(8'hF4, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[16] = row(8'h90, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[17] = row(8'h80, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[18] = row(8'h80, 1'b0, PREDICT, 16'h0000, 16'h0000);
    dir_rows[19] = row(8'hE2, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[20] = row(8'h82, 1'b1, 1, u8u16_pkg::UNIT_REPLACE, 16'h0000);
    dir_rows[21] = row(8'hC3, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[22] = row(8'h41, 1'b0, PREDICT, 16'h0000, 16'h0000);
    dir_rows[23] = row(8'hF7, 1'b0, 0, 16'h0000, 16'h0000);
    dir_rows[24] = row(8'hBF, 1'b1, PREDICT, 16'h0000, 16'h0000);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < 25; i++)
      send_byte(dir_rows[i].text_byte, dir_rows[i].last_of_text, dir_rows[i].n,
                dir_rows[i].u0, dir_rows[i].u1);
    drain_outputs();

    random_bytes = 0;
    while (random_bytes < RANDOM_BYTES) begin
      build_text();
      for (int i = 0; i < text_q.size(); i++) begin
        if (random_bytes >= QUIET_FROM) quiet = 1'b1;
        send_byte(text_q[i], i == text_q.size() - 1, PREDICT, 16'h0000, 16'h0000);
        random_bytes++;
      end
      if (!quiet && $urandom_range(0, 5) == 0) drain_outputs();
    end

    in_valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (pending_units.size() != 0)
      report($sformatf("%0d code units never arrived", pending_units.size()));

    $display("Sent %0d bytes in %0d texts and checked %0d code units.", bytes_in, texts_in,
             units_out);
    $display("The units held %0d replacements and %0d surrogate pairs.", repl_out, pairs_out);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches.", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
